[design/arqp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the reference-to-query position unit.
package arqp_pkg;

   localparam int POS_BITS   = 24;
   localparam int DELTA_BITS = POS_BITS + 1;
   localparam int REM_BITS   = POS_BITS + 1;   // distance left to the target, 0..2^POS_BITS
   localparam int OFF_BITS   = POS_BITS + 2;   // signed query offset
   localparam int SUM_BITS   = POS_BITS + 4;   // signed mapped position before clamping

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic OP_START = 1'b0;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_LOW     = 2'd2;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_STEP,
      KIND_END
   } kind_type;

   // Classified item as it sits in the queue.
   typedef struct packed {
      kind_type              kind;
      logic [REM_BITS-1:0]   amount;   // start: initial distance; step: block size |d|-1
      logic [POS_BITS-1:0]   base;
      logic                  minus;
      logic                  outside;
      logic                  fwd;      // step on the reference (d > 0)
   } entry_type;

   // Finished walk waiting for output formatting.
   typedef struct packed {
      logic signed [OFF_BITS-1:0] qoff;
      logic [POS_BITS-1:0]        base;
      logic                       minus;
      logic                       outside;
   } fin_type;

endpackage

[design/arqp_front.sv]
`timescale 1ns / 1ps
// Front end: classifies each incoming item into a queue entry.
module arqp_front import arqp_pkg::*; (
   input  logic                         op,
   input  logic [POS_BITS-1:0]          ref_start,
   input  logic [POS_BITS-1:0]          ref_end,
   input  logic [POS_BITS-1:0]          query_start,
   input  logic                         strand,
   input  logic [POS_BITS-1:0]          target_pos,
   input  logic signed [DELTA_BITS-1:0] delta,
   output entry_type                    entry
);

   logic [DELTA_BITS-1:0] delta_raw;
   logic [REM_BITS-1:0]   delta_mag;

   always_comb begin
      delta_raw = delta;
      delta_mag = delta_raw[DELTA_BITS-1] ? REM_BITS'(~delta_raw + 1'b1) : REM_BITS'(delta_raw);

      entry = '0;
      if (op == OP_START) begin
         entry.kind    = KIND_START;
         // target - (ref_start - 1): distance from the walk origin
         entry.amount  = {1'b0, target_pos} - {1'b0, ref_start} + REM_BITS'(1);
         entry.base    = query_start;
         entry.minus   = strand;
         entry.outside = (target_pos < ref_start) || (target_pos > ref_end);
      end else if (delta_raw == '0) begin
         entry.kind = KIND_END;
      end else begin
         entry.kind   = KIND_STEP;
         entry.amount = delta_mag - REM_BITS'(1);
         entry.fwd    = ~delta_raw[DELTA_BITS-1];
      end
   end

endmodule

[design/arqp_fifo.sv]
`timescale 1ns / 1ps
// Short item queue between the front end and the walk engine.
module arqp_fifo import arqp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != FIFO_CNT_BITS'(FIFO_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_entry  = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/arqp_back.sv]
`timescale 1ns / 1ps
// Walk engine: applies start, step and end items to the running offsets.
module arqp_back import arqp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   output logic      head_ready,
   input  entry_type head,
   output logic      fin_valid,
   output fin_type   fin,
   input  logic      fin_ready
);

   // remain = target_offset - ref_offset; never negative while walking
   logic [REM_BITS-1:0]        remain_ff, remain_in;
   logic signed [OFF_BITS-1:0] qoff_ff, qoff_in;
   logic [POS_BITS-1:0]        base_ff, base_in;
   logic                       minus_ff, minus_in;
   logic                       reached_ff, reached_in;
   logic                       outside_ff, outside_in;
   logic                       fin_valid_ff, fin_valid_in;
   fin_type                    fin_ff, fin_in;

   logic                       fin_free, take, walking, hit;
   logic [REM_BITS-1:0]        qadd;
   logic [OFF_BITS:0]          qsum;
   logic signed [OFF_BITS-1:0] qoff_sat;

   always_comb begin
      fin_free   = !fin_valid_ff || fin_ready;
      head_ready = (head.kind != KIND_END) || fin_free;
      take       = head_valid && head_ready;
      walking    = !reached_ff && !outside_ff;
      hit        = (remain_ff <= head.amount);

      // query advance: the remaining distance on a hit or an end,
      // otherwise the block plus one query-only column when d < 0
      if (head.kind == KIND_STEP && !hit) begin
         qadd = head.amount + REM_BITS'(!head.fwd);
      end else begin
         qadd = remain_ff;
      end
      qsum     = {qoff_ff[OFF_BITS-1], qoff_ff} + (OFF_BITS + 1)'(qadd);
      // qadd is never negative, so only the top can overflow
      qoff_sat = (qsum[OFF_BITS] != qsum[OFF_BITS-1]) ?
                 {1'b0, {(OFF_BITS-1){1'b1}}} : qsum[OFF_BITS-1:0];

      remain_in    = remain_ff;
      qoff_in      = qoff_ff;
      base_in      = base_ff;
      minus_in     = minus_ff;
      reached_in   = reached_ff;
      outside_in   = outside_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      fin_in       = fin_ff;

      if (take) begin
         unique case (head.kind)
            KIND_START: begin
               remain_in  = head.amount;
               qoff_in    = -OFF_BITS'(1);
               base_in    = head.base;
               minus_in   = head.minus;
               reached_in = 1'b0;
               outside_in = head.outside;
            end
            KIND_STEP: begin
               if (walking) begin
                  qoff_in = qoff_sat;
                  if (hit) begin
                     remain_in  = '0;
                     reached_in = 1'b1;
                  end else begin
                     remain_in  = remain_ff - head.amount - REM_BITS'(head.fwd);
                     reached_in = (remain_ff - head.amount - REM_BITS'(head.fwd)) == '0;
                  end
               end
            end
            KIND_END: begin
               if (walking) begin
                  qoff_in    = qoff_sat;
                  remain_in  = '0;
                  reached_in = 1'b1;
               end
               fin_valid_in   = 1'b1;
               fin_in.qoff    = walking ? qoff_sat : qoff_ff;
               fin_in.base    = base_ff;
               fin_in.minus   = minus_ff;
               fin_in.outside = outside_ff;
            end
            default: begin
            end
         endcase
      end

      fin_valid = fin_valid_ff;
      fin       = fin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= REM_BITS'(1);
         qoff_ff      <= -OFF_BITS'(1);
         base_ff      <= '0;
         minus_ff     <= 1'b0;
         reached_ff   <= 1'b0;
         outside_ff   <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         qoff_ff      <= qoff_in;
         base_ff      <= base_in;
         minus_ff     <= minus_in;
         reached_ff   <= reached_in;
         outside_ff   <= outside_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

endmodule

[design/arqp_emit.sv]
`timescale 1ns / 1ps
// Output stage: turns a finished offset into a query position and status.
module arqp_emit import arqp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                fin_valid,
   output logic                fin_ready,
   input  fin_type             fin,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_BITS-1:0] rsp_query_pos,
   output logic [1:0]          rsp_status
);

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic [1:0]                 status_ff, status_in;
   logic signed [SUM_BITS-1:0] qoff_ext, mapped;

   always_comb begin
      fin_ready = !rsp_valid_ff || rsp_ready;
      qoff_ext  = SUM_BITS'(fin.qoff);
      mapped    = $signed({{(SUM_BITS-POS_BITS){1'b0}}, fin.base})
                  + (fin.minus ? -qoff_ext : qoff_ext);

      if (fin.outside) begin
         pos_in    = '0;
         status_in = STATUS_OUTSIDE;
      end else if (mapped[SUM_BITS-1] || mapped == '0) begin
         pos_in    = '0;
         status_in = STATUS_LOW;
      end else if (|mapped[SUM_BITS-2:POS_BITS]) begin
         pos_in    = '1;
         status_in = STATUS_OK;
      end else begin
         pos_in    = mapped[POS_BITS-1:0];
         status_in = STATUS_OK;
      end

      rsp_valid_in = fin_valid || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         pos_ff    <= pos_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_query_pos = pos_ff;
   assign rsp_status    = status_ff;

endmodule

[design/alignment_ref_to_query_position_unit.sv]
`timescale 1ns / 1ps
// Reference-to-query position lift through a delta-encoded gapped alignment.
// A start item (req_op = 0) loads ref_start, ref_end, query_start, strand
// and target_pos and resets the walk; each later item carries one signed
// delta. A nonzero delta stands for |d|-1 matched columns followed by one
// reference-only column (d > 0, a gap in the query) or one query-only
// column (d < 0); the walk stops once the target is reached.
// Delta 0 closes the alignment and produces one item on the rsp_ channel:
// query_start +/- query offset, with status 0 ok, 1 target outside
// [ref_start, ref_end], 2 mapped position below 1 (query_pos 0 then);
// a position above the 24-bit range clamps to all ones. Start and nonzero
// delta items produce nothing. Repeated delta 0 items repeat the result.
// Throughput: one item per clock, sustained, in any mix, while rsp_ready is
// held high; the bound is the walk engine's state loop, one compare and one
// add on the running offsets per cycle. An ending delta is registered by the
// queue, then by the walk engine's result slot and then by the output
// register, which drives rsp_valid. The 2-entry queue
// between the classifier and the walk engine and the output register let
// the input keep flowing while a result waits for rsp_ready.
module alignment_ref_to_query_position_unit import arqp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [POS_BITS-1:0]          req_ref_start,
   input  logic [POS_BITS-1:0]          req_ref_end,
   input  logic [POS_BITS-1:0]          req_query_start,
   input  logic                         req_strand,
   input  logic [POS_BITS-1:0]          req_target_pos,
   input  logic signed [DELTA_BITS-1:0] req_delta,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [POS_BITS-1:0]          rsp_query_pos,
   output logic [1:0]                   rsp_status
);

   entry_type front_entry;   // classified item from the front end
   entry_type head_entry;    // oldest queued item
   logic      head_valid, head_ready;
   fin_type   fin;           // finished walk, one per ending delta
   logic      fin_valid, fin_ready;

   // Classifier: start / step / end, block size and initial target distance.
   arqp_front u_front (
      .op          (req_op),
      .ref_start   (req_ref_start),
      .ref_end     (req_ref_end),
      .query_start (req_query_start),
      .strand      (req_strand),
      .target_pos  (req_target_pos),
      .delta       (req_delta),
      .entry       (front_entry)
   );

   // Decoupling queue; req_ready is simply "queue has room".
   arqp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_entry (front_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_entry  (head_entry)
   );

   // Walk engine; stalls only on an ending delta while its result slot is full.
   arqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head       (head_entry),
      .fin_valid  (fin_valid),
      .fin        (fin),
      .fin_ready  (fin_ready)
   );

   // Final position, clamping and status; registered output.
   arqp_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin           (fin),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_query_pos (rsp_query_pos),
      .rsp_status    (rsp_status)
   );

endmodule
